// File: rtl/core/iprw_pkg.sv
// shared types, constants and helpers for the ipv4 rewrite and checksum block
// no dependencies
`timescale 1ns / 1ps

package iprw_pkg;

    localparam int FRAME_BYTES = 2048;
    localparam int AW          = $clog2(FRAME_BYTES);
    localparam int CNT_W       = AW + 1;
    localparam int SUM_W       = AW + 17;
    localparam int OUT_LEN_W   = 12;

    localparam int ETH_LEN     = 14;
    localparam int IP_LEN      = 20;
    localparam int HDR_FIRST   = 12;
    localparam int HDR_BYTES   = 22;
    localparam int TTL_POS     = 22;
    localparam int IPCK_POS    = 24;
    localparam int SRC_POS     = 26;
    localparam int L4_START    = 34;
    localparam int TCP_CK_OFF  = 16;
    localparam int UDP_CK_OFF  = 6;
    localparam int PATCH_STEPS = 9;
    localparam int PATCH_W     = 4;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'h06;
    localparam logic [7:0]  PROTO_UDP      = 8'h11;
    localparam logic [7:0]  TTL_LIMIT_RST  = 8'd10;
    localparam logic [7:0]  NEW_TTL_RST    = 8'd64;
    localparam logic [7:0]  XOR_KEY_RST    = 8'h5a;

    typedef enum logic [2:0] {
        CFG_REWRITE_EN = 3'd0,
        CFG_NEW_SRC    = 3'd1,
        CFG_TTL_LIMIT  = 3'd2,
        CFG_NEW_TTL    = 3'd3,
        CFG_XOR_KEY    = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_VERDICT = 2'd0,
        KIND_BYTE    = 2'd1,
        KIND_NONE    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        V_FWD       = 3'd0,
        V_NOT_IPV4  = 3'd1,
        V_TTL       = 3'd2,
        V_PROTO     = 3'd3,
        V_MALFORMED = 3'd4
    } verdict_t;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        kind_t                  result_kind;
        verdict_t               verdict;
        logic [OUT_LEN_W-1:0]   out_length;
        logic [7:0]             out_byte;
        logic                   out_last;
    } out_item_t;

    typedef struct packed {
        logic push;
        logic judge;
        logic sweep;
        logic fold;
        logic patch;
        logic pull_rd;
        logic load_verdict;
        logic load_byte;
        logic load_none;
    } cmd_t;

    typedef struct packed {
        logic fwd;
        logic sweep_done;
        logic patch_done;
        logic pull_avail;
        logic out_free;
    } status_t;

    function automatic logic [15:0] csum_fold(input logic [SUM_W-1:0] s);
        logic [16:0] a;
        logic [16:0] b;
        a = 17'(s[15:0]) + 17'(s[SUM_W-1:16]);
        b = 17'(a[15:0]) + 17'(a[16]);
        return ~b[15:0];
    endfunction

endpackage

// File: rtl/core/iprw_ctrl.sv
// sequencing state machine for push, judge, checksum sweep, patch and pull
// depends on iprw_pkg
`timescale 1ns / 1ps

module iprw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  iprw_pkg::in_item_t s_data,
    input  iprw_pkg::status_t st,
    output iprw_pkg::cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE         = 9'b000000001,
        ST_JUDGE        = 9'b000000010,
        ST_SWEEP        = 9'b000000100,
        ST_FOLD         = 9'b000001000,
        ST_PATCH        = 9'b000010000,
        ST_EMIT_VERDICT = 9'b000100000,
        ST_PULL_RD      = 9'b001000000,
        ST_PULL_OUT     = 9'b010000000,
        ST_EMIT_NONE    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_data.func) begin
                        cmd.push = 1'b1;
                        if (s_data.last_byte) begin
                            state_next = ST_JUDGE;
                        end
                    end else if (st.pull_avail) begin
                        state_next = ST_PULL_RD;
                    end else begin
                        state_next = ST_EMIT_NONE;
                    end
                end
            end
            ST_JUDGE: begin
                cmd.judge  = 1'b1;
                state_next = st.fwd ? ST_SWEEP : ST_EMIT_VERDICT;
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (st.sweep_done) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold   = 1'b1;
                state_next = ST_PATCH;
            end
            ST_PATCH: begin
                cmd.patch = 1'b1;
                if (st.patch_done) begin
                    state_next = ST_EMIT_VERDICT;
                end
            end
            ST_EMIT_VERDICT: begin
                if (st.out_free) begin
                    cmd.load_verdict = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_PULL_RD: begin
                cmd.pull_rd = 1'b1;
                state_next  = ST_PULL_OUT;
            end
            ST_PULL_OUT: begin
                if (st.out_free) begin
                    cmd.load_byte = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT_NONE: begin
                if (st.out_free) begin
                    cmd.load_none = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/iprw_datapath.sv
// frame store, header capture, checksum accumulators, config and result registers
// depends on iprw_pkg
`timescale 1ns / 1ps

module iprw_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  iprw_pkg::in_item_t  s_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                m_valid,
    input  logic                m_ready,
    output iprw_pkg::out_item_t m_data,
    input  iprw_pkg::cmd_t      cmd,
    output iprw_pkg::status_t   st
);

    localparam int AW    = iprw_pkg::AW;
    localparam int CNT_W = iprw_pkg::CNT_W;
    localparam int SUM_W = iprw_pkg::SUM_W;

    localparam logic [iprw_pkg::PATCH_W-1:0] P_TTL   = 4'd0;
    localparam logic [iprw_pkg::PATCH_W-1:0] P_SRC0  = 4'd1;
    localparam logic [iprw_pkg::PATCH_W-1:0] P_SRC1  = 4'd2;
    localparam logic [iprw_pkg::PATCH_W-1:0] P_SRC2  = 4'd3;
    localparam logic [iprw_pkg::PATCH_W-1:0] P_SRC3  = 4'd4;
    localparam logic [iprw_pkg::PATCH_W-1:0] P_IPCK0 = 4'd5;
    localparam logic [iprw_pkg::PATCH_W-1:0] P_IPCK1 = 4'd6;
    localparam logic [iprw_pkg::PATCH_W-1:0] P_L4CK0 = 4'd7;
    localparam logic [iprw_pkg::PATCH_W-1:0] P_L4CK1 = 4'd8;

    // configuration
    logic        rewrite_en_reg;
    logic [31:0] new_src_reg;
    logic [7:0]  ttl_limit_reg;
    logic [7:0]  new_ttl_reg;
    logic [7:0]  xor_key_reg;

    // frame tracking
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;
    logic [7:0]       hdr_reg [iprw_pkg::HDR_BYTES];
    logic             pending_reg;
    logic [CNT_W-1:0] rp_reg;
    logic [CNT_W-1:0] plen_reg;
    iprw_pkg::verdict_t verdict_reg;

    // checksum sweep
    logic [CNT_W-1:0] sweep_addr_reg;
    logic [CNT_W-1:0] sweep_end_reg;
    logic [AW-1:0]    ck_pos_reg;
    logic [SUM_W-1:0] hsum_reg;
    logic [SUM_W-1:0] tsum_reg;
    logic             rd_valid_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic [15:0]      hck_reg;
    logic [15:0]      tck_reg;
    logic [iprw_pkg::PATCH_W-1:0] patch_idx_reg;

    // store
    logic [7:0]    mem [iprw_pkg::FRAME_BYTES];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    logic                m_valid_reg;
    iprw_pkg::out_item_t m_data_reg;

    // judge
    logic [15:0]        eth_type;
    logic [15:0]        total;
    logic [7:0]         ttl;
    logic [7:0]         proto;
    logic [15:0]        tlen;
    logic [4:0]         cko;
    logic [16:0]        tot_end;
    iprw_pkg::verdict_t verdict_now;
    logic               sweep_issue;
    logic               can_store;
    logic [CNT_W-1:0]   pull_pos;

    // sweep byte
    logic [7:0]       sw_val;
    logic [SUM_W-1:0] sw_word;
    logic             sw_hdr;
    logic             sw_l4;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign eth_type = {hdr_reg[0], hdr_reg[1]};
    assign total    = {hdr_reg[4], hdr_reg[5]};
    assign ttl      = hdr_reg[iprw_pkg::TTL_POS - iprw_pkg::HDR_FIRST];
    assign proto    = hdr_reg[iprw_pkg::TTL_POS + 1 - iprw_pkg::HDR_FIRST];
    assign tlen     = total - 16'(iprw_pkg::IP_LEN);
    assign cko      = (proto == iprw_pkg::PROTO_TCP) ? 5'(iprw_pkg::TCP_CK_OFF)
                                                     : 5'(iprw_pkg::UDP_CK_OFF);
    assign tot_end  = 17'(iprw_pkg::ETH_LEN) + 17'(total);
    assign can_store = (count_reg < CNT_W'(iprw_pkg::FRAME_BYTES));
    assign pull_pos  = CNT_W'(iprw_pkg::ETH_LEN) + rp_reg;

    always_comb begin
        if (ovf_reg || count_reg < CNT_W'(iprw_pkg::ETH_LEN)) begin
            verdict_now = iprw_pkg::V_MALFORMED;
        end else if (eth_type != iprw_pkg::ETHERTYPE_IPV4) begin
            verdict_now = iprw_pkg::V_NOT_IPV4;
        end else if (count_reg < CNT_W'(iprw_pkg::L4_START)) begin
            verdict_now = iprw_pkg::V_MALFORMED;
        end else if (ttl > ttl_limit_reg) begin
            verdict_now = iprw_pkg::V_TTL;
        end else if (proto != iprw_pkg::PROTO_TCP && proto != iprw_pkg::PROTO_UDP) begin
            verdict_now = iprw_pkg::V_PROTO;
        end else if (total < 16'(iprw_pkg::IP_LEN) || tot_end > 17'(count_reg)) begin
            verdict_now = iprw_pkg::V_MALFORMED;
        end else if (tlen < 16'(cko) + 16'd2) begin
            verdict_now = iprw_pkg::V_MALFORMED;
        end else begin
            verdict_now = iprw_pkg::V_FWD;
        end
    end

    assign sweep_issue = cmd.sweep && (sweep_addr_reg != sweep_end_reg);

    assign st.fwd        = (verdict_now == iprw_pkg::V_FWD);
    assign st.sweep_done = (sweep_addr_reg == sweep_end_reg) && !rd_valid_reg;
    assign st.patch_done = (patch_idx_reg == iprw_pkg::PATCH_W'(iprw_pkg::PATCH_STEPS - 1));
    assign st.pull_avail = pending_reg && (rp_reg < plen_reg)
                           && (pull_pos < CNT_W'(iprw_pkg::FRAME_BYTES));
    assign st.out_free   = !m_valid_reg || m_ready;

    // header substitutions applied while summing
    always_comb begin
        sw_val = rd_data_reg;
        if (rd_addr_reg == AW'(iprw_pkg::TTL_POS)) begin
            sw_val = new_ttl_reg;
        end
        if (rd_addr_reg == AW'(iprw_pkg::IPCK_POS)
            || rd_addr_reg == AW'(iprw_pkg::IPCK_POS + 1)) begin
            sw_val = 8'h00;
        end
        if (rewrite_en_reg) begin
            case (rd_addr_reg)
                AW'(iprw_pkg::SRC_POS):     sw_val = new_src_reg[31:24];
                AW'(iprw_pkg::SRC_POS + 1): sw_val = new_src_reg[23:16];
                AW'(iprw_pkg::SRC_POS + 2): sw_val = new_src_reg[15:8];
                AW'(iprw_pkg::SRC_POS + 3): sw_val = new_src_reg[7:0];
                default:                    ;
            endcase
        end
        if (rd_addr_reg == ck_pos_reg || rd_addr_reg == ck_pos_reg + AW'(1)) begin
            sw_val = 8'h00;
        end
        sw_word = rd_addr_reg[0] ? SUM_W'(sw_val) : SUM_W'({sw_val, 8'h00});
        sw_hdr  = rd_addr_reg < AW'(iprw_pkg::L4_START);
        sw_l4   = rd_addr_reg >= AW'(iprw_pkg::SRC_POS);
    end

    // store write and read ports
    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        if (cmd.push && can_store) begin
            mem_we = 1'b1;
            mem_wa = count_reg[AW-1:0];
            mem_wd = s_data.data_byte;
        end else if (cmd.patch) begin
            mem_we = 1'b1;
            unique case (patch_idx_reg)
                P_TTL: begin
                    mem_wa = AW'(iprw_pkg::TTL_POS);
                    mem_wd = new_ttl_reg;
                end
                P_SRC0: begin
                    mem_we = rewrite_en_reg;
                    mem_wa = AW'(iprw_pkg::SRC_POS);
                    mem_wd = new_src_reg[31:24];
                end
                P_SRC1: begin
                    mem_we = rewrite_en_reg;
                    mem_wa = AW'(iprw_pkg::SRC_POS + 1);
                    mem_wd = new_src_reg[23:16];
                end
                P_SRC2: begin
                    mem_we = rewrite_en_reg;
                    mem_wa = AW'(iprw_pkg::SRC_POS + 2);
                    mem_wd = new_src_reg[15:8];
                end
                P_SRC3: begin
                    mem_we = rewrite_en_reg;
                    mem_wa = AW'(iprw_pkg::SRC_POS + 3);
                    mem_wd = new_src_reg[7:0];
                end
                P_IPCK0: begin
                    mem_wa = AW'(iprw_pkg::IPCK_POS);
                    mem_wd = hck_reg[15:8];
                end
                P_IPCK1: begin
                    mem_wa = AW'(iprw_pkg::IPCK_POS + 1);
                    mem_wd = hck_reg[7:0];
                end
                P_L4CK0: begin
                    mem_wa = ck_pos_reg;
                    mem_wd = tck_reg[15:8];
                end
                P_L4CK1: begin
                    mem_wa = ck_pos_reg + AW'(1);
                    mem_wd = tck_reg[7:0];
                end
                default: begin
                    mem_we = 1'b0;
                end
            endcase
        end
        mem_re = sweep_issue || cmd.pull_rd;
        mem_ra = cmd.pull_rd ? pull_pos[AW-1:0] : sweep_addr_reg[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // header byte capture
    always_ff @(posedge aclk) begin
        for (int i = 0; i < iprw_pkg::HDR_BYTES; i++) begin
            if (cmd.push && count_reg == CNT_W'(iprw_pkg::HDR_FIRST + i)) begin
                hdr_reg[i] <= s_data.data_byte;
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rewrite_en_reg <= 1'b0;
            new_src_reg    <= '0;
            ttl_limit_reg  <= iprw_pkg::TTL_LIMIT_RST;
            new_ttl_reg    <= iprw_pkg::NEW_TTL_RST;
            xor_key_reg    <= iprw_pkg::XOR_KEY_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                iprw_pkg::CFG_REWRITE_EN: rewrite_en_reg <= cfg_data[0];
                iprw_pkg::CFG_NEW_SRC:    new_src_reg    <= cfg_data;
                iprw_pkg::CFG_TTL_LIMIT:  ttl_limit_reg  <= cfg_data[7:0];
                iprw_pkg::CFG_NEW_TTL:    new_ttl_reg    <= cfg_data[7:0];
                iprw_pkg::CFG_XOR_KEY:    xor_key_reg    <= cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

    // checksum datapath payload
    always_ff @(posedge aclk) begin
        rd_addr_reg <= sweep_addr_reg[AW-1:0];
        if (cmd.judge) begin
            verdict_reg    <= verdict_now;
            plen_reg       <= count_reg - CNT_W'(iprw_pkg::ETH_LEN);
            sweep_addr_reg <= CNT_W'(iprw_pkg::ETH_LEN);
            sweep_end_reg  <= CNT_W'(tot_end);
            ck_pos_reg     <= AW'(iprw_pkg::L4_START) + AW'(cko);
            hsum_reg       <= '0;
            tsum_reg       <= SUM_W'(proto) + SUM_W'(tlen);
        end else begin
            if (sweep_issue) begin
                sweep_addr_reg <= sweep_addr_reg + CNT_W'(1);
            end
            if (rd_valid_reg) begin
                if (sw_hdr) begin
                    hsum_reg <= hsum_reg + sw_word;
                end
                if (sw_l4) begin
                    tsum_reg <= tsum_reg + sw_word;
                end
            end
        end
        if (cmd.fold) begin
            hck_reg       <= iprw_pkg::csum_fold(hsum_reg);
            tck_reg       <= iprw_pkg::csum_fold(tsum_reg);
            patch_idx_reg <= '0;
        end else if (cmd.patch) begin
            patch_idx_reg <= patch_idx_reg + iprw_pkg::PATCH_W'(1);
        end
    end

    // frame and pull control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            pending_reg  <= 1'b0;
            rp_reg       <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= sweep_issue;
            if (cmd.push) begin
                pending_reg <= 1'b0;
                rp_reg      <= '0;
                if (can_store) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.judge) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.load_verdict) begin
                pending_reg <= (verdict_reg == iprw_pkg::V_FWD);
                rp_reg      <= '0;
            end
            if (cmd.load_none) begin
                pending_reg <= 1'b0;
            end
            if (cmd.load_byte) begin
                if (rp_reg + CNT_W'(1) == plen_reg) begin
                    pending_reg <= 1'b0;
                    rp_reg      <= '0;
                end else begin
                    rp_reg <= rp_reg + CNT_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_verdict || cmd.load_byte || cmd.load_none) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_verdict) begin
            m_data_reg.result_kind <= iprw_pkg::KIND_VERDICT;
            m_data_reg.verdict     <= verdict_reg;
            m_data_reg.out_length  <= (verdict_reg == iprw_pkg::V_FWD)
                                      ? iprw_pkg::OUT_LEN_W'(plen_reg) : '0;
            m_data_reg.out_byte    <= '0;
            m_data_reg.out_last    <= 1'b0;
        end else if (cmd.load_byte) begin
            m_data_reg.result_kind <= iprw_pkg::KIND_BYTE;
            m_data_reg.verdict     <= iprw_pkg::V_FWD;
            m_data_reg.out_length  <= '0;
            m_data_reg.out_byte    <= rd_data_reg ^ xor_key_reg;
            m_data_reg.out_last    <= (rp_reg + CNT_W'(1) == plen_reg);
        end else if (cmd.load_none) begin
            m_data_reg.result_kind <= iprw_pkg::KIND_NONE;
            m_data_reg.verdict     <= iprw_pkg::V_FWD;
            m_data_reg.out_length  <= '0;
            m_data_reg.out_byte    <= '0;
            m_data_reg.out_last    <= 1'b0;
        end
    end

endmodule

// File: rtl/core/ipv4_packet_rewrite_checksum_top.sv
// top level: ipv4 header rewrite with tcp/udp and ip checksum recompute
// depends on iprw_pkg, iprw_ctrl, iprw_datapath
// push: one byte per cycle while s_ready is high; after the final byte the frame is judged
// and, when forwarded, checksummed (memory sweep over the ip packet, fold, 9 patch steps)
// pull: returns the next pending byte, or none when nothing is pending; s_ready low until done
// reset: synchronous active low, clears control and config; frame store is not cleared
`timescale 1ns / 1ps

module ipv4_packet_rewrite_checksum_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  iprw_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output iprw_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    iprw_pkg::cmd_t    cmd;
    iprw_pkg::status_t st;

    iprw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .st      (st),
        .cmd     (cmd)
    );

    iprw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// File: rtl/core/iprw_checker.sv
// port-level checks for the ipv4 rewrite block, bound to the top level
// depends on iprw_pkg and ipv4_packet_rewrite_checksum_top
`timescale 1ns / 1ps

module iprw_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input iprw_pkg::out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_byte_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind != iprw_pkg::KIND_BYTE
        |-> m_data.out_byte == 8'h00 && !m_data.out_last)
        else $error("byte fields set on non-byte result");

    a_none_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == iprw_pkg::KIND_NONE
        |-> m_data.verdict == iprw_pkg::V_FWD && m_data.out_length == '0)
        else $error("empty pull carries data");

    a_drop_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == iprw_pkg::KIND_VERDICT
        && m_data.verdict != iprw_pkg::V_FWD |-> m_data.out_length == '0)
        else $error("dropped frame reports a length");

endmodule

bind ipv4_packet_rewrite_checksum_top iprw_checker u_iprw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
